@@ hw/rtl/tcpas_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpas_pkg
// Shared types and constants of the two-class priority aging scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpas_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 20;
  localparam int BURST_W     = 12;
  localparam int ID_W        = 8;

  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] AGING_RESET = TIME_W'(100);

  typedef enum logic [1:0] {
    OP_ENQ_LOW  = 2'd0,
    OP_ENQ_HIGH = 2'd1,
    OP_SERVE    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [BURST_W-1:0] burst;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              high_class;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] wait_time;
    logic              last;
  } rsp_t;

  // One queued job as held in a queue memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  stamp;
    logic [BURST_W-1:0] burst;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcpas_ram.sv @@
// ----------------------------------------------------------------------------
// tcpas_ram
// Job queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpas_ram (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [tcpas_pkg::PTR_W-1:0]  waddr,
  input  wire  tcpas_pkg::entry_t      wdata,
  input  wire  [tcpas_pkg::PTR_W-1:0]  raddr,
  output tcpas_pkg::entry_t            rdata
);

  tcpas_pkg::entry_t mem [tcpas_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/two_class_priority_aging_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// two_class_priority_aging_scheduler_top
// Two-class FIFO job scheduler with aging, one memory per class queue.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present req and raise start; the item is taken at a
//   rising edge where start is high and busy is low. req.op selects enqueue
//   low, enqueue high, or a serve round (any op with bit 1 set).
//   Result channel: each result item sits on rsp for exactly one cycle with
//   strobe high; rsp.last marks the final result of a command. The receiver
//   cannot stall, so results are never held.
//   Config channel: cfg_data is the aging threshold, written when cfg_valid
//   and cfg_ready are both high; cfg_ready is high only while idle.
// Sequencing:
//   Enqueue: result strobe in the cycle after acceptance; the block passes
//   through FIN and takes the next command once it is back in IDLE.
//   Serve round: every result costs an EVAL decision, followed by GAP for
//   the queue memory to return the new head after the head pointer advances
//   (synchronous read), or by FIN after the final result.
// Reset:
//   rst clears heads, counts, arrival counters and elapsed time and loads
//   the threshold with 100. Queue memories are not cleared; counts gate
//   every read.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_aging_scheduler_top (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  tcpas_pkg::req_t           req,
  output logic                            strobe,
  output tcpas_pkg::rsp_t                 rsp,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [tcpas_pkg::TIME_W-1:0]    cfg_data
);

  localparam int PTR_W  = tcpas_pkg::PTR_W;
  localparam int CNT_W  = tcpas_pkg::CNT_W;
  localparam int TIME_W = tcpas_pkg::TIME_W;
  localparam int ID_W   = tcpas_pkg::ID_W;
  localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W+1)'(tcpas_pkg::QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(tcpas_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(tcpas_pkg::QUEUE_DEPTH - 1);

  // Sequencer: IDLE takes commands, EVAL picks the next service from the
  // registered head entries, GAP waits for the memory after a head move,
  // FIN shows the final result.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_GAP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  typedef enum logic {
    PH_AGE_HIGH = 1'b0,
    PH_AGE_LOW  = 1'b1
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [PTR_W-1:0]  high_head, high_head_next, low_head, low_head_next;
  logic [CNT_W-1:0]  high_count, high_count_next, low_count, low_count_next;
  logic [ID_W-1:0]   high_arrivals, high_arrivals_next;
  logic [ID_W-1:0]   low_arrivals, low_arrivals_next;
  logic [TIME_W-1:0] elapsed_time, elapsed_time_next;
  logic [TIME_W-1:0] aging_threshold;
  tcpas_pkg::rsp_t   rsp_next;
  logic              strobe_next;

  // Queue memory ports
  logic              hi_we, lo_we;
  logic [PTR_W-1:0]  wr_addr;
  tcpas_pkg::entry_t wr_entry;
  tcpas_pkg::entry_t hi_rdata, lo_rdata;

  // Enqueue datapath
  logic              enq_high;
  logic [CNT_W-1:0]  enq_count;
  logic [PTR_W-1:0]  enq_head;
  logic [PTR_W:0]    tail_sum;
  logic [ID_W-1:0]   enq_id;

  // Service datapath
  logic [TIME_W-1:0] high_wait, low_wait, srv_wait;
  logic              high_aged, low_aged;
  logic              do_serve, srv_high, srv_last;
  tcpas_pkg::entry_t srv_ent;
  logic [TIME_W:0]   elapsed_sum;

  tcpas_ram u_high_ram (
    .clk   (clk),
    .we    (hi_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (high_head),
    .rdata (hi_rdata)
  );

  tcpas_ram u_low_ram (
    .clk   (clk),
    .we    (lo_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (low_head),
    .rdata (lo_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Head waits; stamps never exceed elapsed time, but clamp at zero anyway.
  assign high_wait = (elapsed_time >= hi_rdata.stamp) ? elapsed_time - hi_rdata.stamp : '0;
  assign low_wait  = (elapsed_time >= lo_rdata.stamp) ? elapsed_time - lo_rdata.stamp : '0;
  assign high_aged = (high_count != '0) && (high_wait > aging_threshold);
  assign low_aged  = (low_count != '0) && (low_wait > aging_threshold);

  // Enqueue target: tail = head + count, wrapped once.
  assign enq_high  = (req.op == tcpas_pkg::OP_ENQ_HIGH);
  assign enq_count = enq_high ? high_count : low_count;
  assign enq_head  = enq_high ? high_head : low_head;
  assign enq_id    = (enq_high ? high_arrivals : low_arrivals) + ID_W'(1);
  assign tail_sum  = {1'b0, enq_head} + {1'b0, enq_count[PTR_W-1:0]};
  assign wr_addr   = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                             : tail_sum[PTR_W-1:0];

  assign wr_entry.id    = enq_id;
  assign wr_entry.stamp = elapsed_time;
  assign wr_entry.burst = req.burst;

  // Service pick for the EVAL cycle: aged high heads, then aged low heads,
  // then one plain service by class priority.
  always_comb begin
    do_serve   = 1'b0;
    srv_high   = 1'b0;
    srv_last   = 1'b1;
    phase_next = phase;
    priority if ((phase == PH_AGE_HIGH) && high_aged) begin
      do_serve = 1'b1;
      srv_high = 1'b1;
      srv_last = 1'b0;
    end else if (low_aged) begin
      do_serve   = 1'b1;
      srv_last   = 1'b0;
      phase_next = PH_AGE_LOW;
    end else if (high_count != '0) begin
      do_serve = 1'b1;
      srv_high = 1'b1;
    end else if (low_count != '0) begin
      do_serve = 1'b1;
    end
    if (state == S_IDLE) begin
      phase_next = PH_AGE_HIGH;
    end else if (state != S_EVAL) begin
      phase_next = phase;
    end
  end

  assign srv_ent     = srv_high ? hi_rdata : lo_rdata;
  assign srv_wait    = srv_high ? high_wait : low_wait;
  assign elapsed_sum = {1'b0, elapsed_time} + (TIME_W+1)'(srv_ent.burst);

  always_comb begin
    state_next         = state;
    high_head_next     = high_head;
    low_head_next      = low_head;
    high_count_next    = high_count;
    low_count_next     = low_count;
    high_arrivals_next = high_arrivals;
    low_arrivals_next  = low_arrivals;
    elapsed_time_next  = elapsed_time;
    rsp_next           = rsp;
    strobe_next        = 1'b0;
    hi_we              = 1'b0;
    lo_we              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((req.op == tcpas_pkg::OP_ENQ_HIGH) || (req.op == tcpas_pkg::OP_ENQ_LOW)) begin
            // Enqueue: one result, shown in FIN.
            state_next          = S_FIN;
            strobe_next         = 1'b1;
            rsp_next.high_class = enq_high;
            rsp_next.wait_time  = '0;
            rsp_next.last       = 1'b1;
            if (enq_count >= DEPTH_CNT) begin
              rsp_next.status = tcpas_pkg::ST_DROPPED;
              rsp_next.job_id = '0;
            end else begin
              rsp_next.status = tcpas_pkg::ST_ACCEPTED;
              rsp_next.job_id = enq_id;
              if (enq_high) begin
                hi_we              = 1'b1;
                high_count_next    = high_count + CNT_W'(1);
                high_arrivals_next = enq_id;
              end else begin
                lo_we             = 1'b1;
                low_count_next    = low_count + CNT_W'(1);
                low_arrivals_next = enq_id;
              end
            end
          end else begin
            state_next = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        strobe_next   = 1'b1;
        rsp_next.last = srv_last;
        if (do_serve) begin
          rsp_next.status     = tcpas_pkg::ST_SERVED;
          rsp_next.high_class = srv_high;
          rsp_next.job_id     = srv_ent.id;
          rsp_next.wait_time  = srv_wait;
          elapsed_time_next   = elapsed_sum[TIME_W] ? tcpas_pkg::TIME_MAX
                                                    : elapsed_sum[TIME_W-1:0];
          if (srv_high) begin
            high_head_next  = (high_head == LAST_PTR) ? '0 : high_head + PTR_W'(1);
            high_count_next = high_count - CNT_W'(1);
          end else begin
            low_head_next  = (low_head == LAST_PTR) ? '0 : low_head + PTR_W'(1);
            low_count_next = low_count - CNT_W'(1);
          end
        end else begin
          rsp_next.status     = tcpas_pkg::ST_EMPTY;
          rsp_next.high_class = 1'b0;
          rsp_next.job_id     = '0;
          rsp_next.wait_time  = '0;
        end
        state_next = srv_last ? S_FIN : S_GAP;
      end

      // Wait in GAP so the memory returns the advanced head.
      S_GAP: begin
        state_next = S_EVAL;
      end

      S_FIN: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_AGE_HIGH;
      high_head       <= '0;
      low_head        <= '0;
      high_count      <= '0;
      low_count       <= '0;
      high_arrivals   <= '0;
      low_arrivals    <= '0;
      elapsed_time    <= '0;
      aging_threshold <= tcpas_pkg::AGING_RESET;
      strobe          <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      high_head     <= high_head_next;
      low_head      <= low_head_next;
      high_count    <= high_count_next;
      low_count     <= low_count_next;
      high_arrivals <= high_arrivals_next;
      low_arrivals  <= low_arrivals_next;
      elapsed_time  <= elapsed_time_next;
      strobe        <= strobe_next;
      if (cfg_valid && cfg_ready) begin
        aging_threshold <= cfg_data;
      end
    end
  end

  // Result payload needs no reset; strobe qualifies it.
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

@@ sim/tcpas_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpas_result_checker
// Watches the command, config and result channels of the scheduler. Keeps a
// private copy of both class queues and the served-time clock, works out the
// result items of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module tcpas_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  tcpas_pkg::req_t              req,
  input  logic                         strobe,
  input  tcpas_pkg::rsp_t              rsp,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tcpas_pkg::TIME_W-1:0] cfg_data,
  output int                           mismatch_count,
  output int                           results_due
);
  import tcpas_pkg::*;

  localparam int LOW_Q  = 0;
  localparam int HIGH_Q = 1;

  entry_t            job_q [2][QUEUE_DEPTH];
  logic [PTR_W-1:0]  q_head [2];
  logic [CNT_W-1:0]  q_count [2];
  logic [ID_W-1:0]   arrivals [2];
  logic [TIME_W-1:0] served_time;
  logic [TIME_W-1:0] threshold;

  rsp_t due_results [$];
  int   mismatches = 0;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  function automatic logic [TIME_W-1:0] head_wait(int c);
    entry_t e;
    e = job_q[c][q_head[c]];
    return (served_time >= e.stamp) ? served_time - e.stamp : '0;
  endfunction

  function automatic bit head_aged(int c);
    return (q_count[c] != 0) && (head_wait(c) > threshold);
  endfunction

  task automatic serve_head(int c);
    entry_t            e;
    rsp_t              r;
    logic [TIME_W:0]   sum;
    e            = job_q[c][q_head[c]];
    r            = '0;
    r.status     = ST_SERVED;
    r.high_class = (c == HIGH_Q);
    r.job_id     = e.id;
    r.wait_time  = head_wait(c);
    due_results.push_back(r);
    q_head[c]    = (q_head[c] == QUEUE_DEPTH - 1) ? '0 : q_head[c] + 1'b1;
    q_count[c]   = q_count[c] - 1'b1;
    // Saturate the served-time clock.
    sum          = {1'b0, served_time} + e.burst;
    served_time  = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
  endtask

  task automatic enqueue_job(int c, logic [BURST_W-1:0] b);
    rsp_t   r;
    entry_t e;
    int     tail;
    r            = '0;
    r.high_class = (c == HIGH_Q);
    if (q_count[c] >= QUEUE_DEPTH) begin
      r.status = ST_DROPPED;
    end else begin
      tail = int'(q_head[c]) + int'(q_count[c]);
      if (tail >= QUEUE_DEPTH) tail = tail - QUEUE_DEPTH;
      arrivals[c]     = arrivals[c] + 1'b1;
      e.id            = arrivals[c];
      e.stamp         = served_time;
      e.burst         = b;
      job_q[c][tail]  = e;
      q_count[c]      = q_count[c] + 1'b1;
      r.status        = ST_ACCEPTED;
      r.job_id        = arrivals[c];
    end
    due_results.push_back(r);
  endtask

  task automatic schedule_command(req_t q);
    rsp_t r;
    if (q.op == OP_ENQ_LOW) begin
      enqueue_job(LOW_Q, q.burst);
    end else if (q.op == OP_ENQ_HIGH) begin
      enqueue_job(HIGH_Q, q.burst);
    end else begin
      while (head_aged(HIGH_Q)) serve_head(HIGH_Q);
      while (head_aged(LOW_Q)) serve_head(LOW_Q);
      if (q_count[HIGH_Q] != 0) begin
        serve_head(HIGH_Q);
      end else if (q_count[LOW_Q] != 0) begin
        serve_head(LOW_Q);
      end else begin
        r        = '0;
        r.status = ST_EMPTY;
        due_results.push_back(r);
      end
    end
    // Mark the final item of this command.
    r      = due_results.pop_back();
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        q_head[c]   = '0;
        q_count[c]  = '0;
        arrivals[c] = '0;
      end
      served_time = '0;
      threshold   = AGING_RESET;
      due_results.delete();
    end else begin
      if (strobe) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result st=%0d hc=%0d id=%0d wait=%0d last=%0d",
                     $realtime, rsp.status, rsp.high_class, rsp.job_id,
                     rsp.wait_time, rsp.last);
        end else begin
          want = due_results.pop_front();
          if (rsp !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp st=%0d hc=%0d id=%0d wait=%0d last=%0d",
                        " got st=%0d hc=%0d id=%0d wait=%0d last=%0d"},
                       $realtime, want.status, want.high_class, want.job_id,
                       want.wait_time, want.last, rsp.status, rsp.high_class,
                       rsp.job_id, rsp.wait_time, rsp.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (start && !busy) schedule_command(req);
    end
    results_due    <= due_results.size();
    mismatch_count <= mismatches;
  end

endmodule

@@ sim/tb_two_class_priority_aging_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_priority_aging_scheduler_top
// Drives enqueue and serve commands into the scheduler, with random gaps,
// and rewrites the aging threshold between phases. A checker instance beside
// the block predicts and compares every result item; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_two_class_priority_aging_scheduler_top;
  import tcpas_pkg::*;

  // Serve round decoded from any op with bit 1 set; this is the unnamed one.
  localparam logic [1:0] OP_SERVE_ALT = 2'd3;
  // Idle cycles after the last result before touching the config channel.
  localparam int         SETTLE_CYCLES = 8;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  req_t              req       = '0;
  logic              cfg_valid = 1'b0;
  logic [TIME_W-1:0] cfg_data  = '0;
  logic              busy;
  logic              strobe;
  logic              cfg_ready;
  rsp_t              rsp;
  int                mismatch_count;
  int                results_due;

  always #6 clk = ~clk;

  two_class_priority_aging_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .strobe    (strobe),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tcpas_result_checker u_result_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .strobe         (strobe),
    .rsp            (rsp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // Hard stop well past the slowest legal run (full serve rounds, long gaps).
  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Gap before the next item: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Burst mix: both extremes, small values and the full range.
  function automatic logic [BURST_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return {BURST_W{1'b1}};
    if (r < 60) return BURST_W'($urandom_range(0, 255));
    return BURST_W'($urandom_range(0, 4095));
  endfunction

  // Present one item, hold start until the block takes it, then idle a bit.
  // Start is left high when no gap follows, so back-to-back items never see
  // a low/high pair in the same step.
  task automatic send_command(logic [1:0] op, logic [BURST_W-1:0] b, bit steady);
    int gap;
    start     <= 1'b1;
    req.op    <= op;
    req.burst <= b;
    do @(posedge clk); while (busy);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the command side until every predicted item has come back.
  // The due count is registered, so step past its update before trusting it.
  task automatic drain_results();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the aging threshold; the block only takes it while idle.
  task automatic write_threshold(logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic with a chosen share of serve rounds and of high class.
  task automatic run_mixed_phase(int n, int serve_pct, int high_pct, bit steady);
    int         r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < serve_pct)
        op = ($urandom_range(0, 7) == 0) ? OP_SERVE_ALT : OP_SERVE;
      else
        op = ($urandom_range(0, 99) < high_pct) ? OP_ENQ_HIGH : OP_ENQ_LOW;
      send_command(op, pick_burst(), steady);
    end
  endtask

  // Fill both queues with long jobs and empty them in two rounds: one plain
  // service, then every other job aged and an empty report. Enough rounds
  // push the served-time clock into saturation.
  task automatic run_saturation_rounds(int rounds);
    for (int k = 0; k < rounds; k++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        send_command(OP_ENQ_HIGH, BURST_W'($urandom_range(3900, 4095)), 1'b0);
        send_command(OP_ENQ_LOW, BURST_W'($urandom_range(3900, 4095)), 1'b0);
      end
      repeat (2) send_command(OP_SERVE, pick_burst(), 1'b0);
    end
  endtask

  initial begin : stimulus
    // Synchronous reset, held from the start of the run.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset threshold in force.
    // Serve with nothing queued: empty report.
    send_command(OP_SERVE, '0, 1'b1);
    // One job per class; the high one goes first at wait zero.
    send_command(OP_ENQ_LOW, '0, 1'b1);
    send_command(OP_ENQ_HIGH, {BURST_W{1'b1}}, 1'b0);
    send_command(OP_SERVE, '0, 1'b0);
    // Low job now aged past the threshold, served, then both queues are empty
    // in the same round. Use the alternate serve encoding here.
    send_command(OP_SERVE_ALT, {BURST_W{1'b1}}, 1'b0);
    // Overfill the high queue: the last push is dropped.
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_command(OP_ENQ_HIGH, BURST_W'($urandom_range(0, 4095)), 1'b0);
    drain_results();

    // Random phases, each under its own threshold. Advance through the
    // extremes first, then random values.
    write_threshold(TIME_MAX);
    run_mixed_phase(16, 35, 50, 1'b0);
    drain_results();

    write_threshold('0);
    run_mixed_phase(16, 30, 40, 1'b1);
    drain_results();

    write_threshold(TIME_W'($urandom_range(0, 3000)));
    run_mixed_phase(16, 20, 70, 1'b0);
    drain_results();

    write_threshold(TIME_W'($urandom_range(0, 1048575)));
    run_mixed_phase(16, 55, 30, 1'b0);
    drain_results();

    write_threshold(TIME_W'($urandom_range(0, 8000)));
    run_mixed_phase(16, 40, 50, 1'b0);
    drain_results();

    // Aged bulk service until the clock saturates, then check that a fresh
    // job sees wait zero.
    write_threshold('0);
    run_saturation_rounds(9);
    send_command(OP_ENQ_HIGH, {BURST_W{1'b1}}, 1'b0);
    send_command(OP_ENQ_LOW, '0, 1'b0);
    send_command(OP_SERVE, '0, 1'b0);
    send_command(OP_SERVE, '0, 1'b0);
    send_command(OP_SERVE, '0, 1'b0);
    drain_results();

    if (mismatch_count == 0 && results_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
